// ===== rtl/core/sactag_pkg.sv =====
package sactag_pkg;

   localparam int NUM_LINES_DEF = 256;
   localparam int ADDR_BITS_DEF = 15;

   localparam int TAG_W     = 14;
   localparam int AGE_W     = 8;
   localparam int CFG_W     = 4;
   localparam int OUT_IDX_W = 8;
   localparam int CSR_W     = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [AGE_W-1:0] AGE_MAX = 8'hFF;

   localparam logic             POLICY_RESET = 1'b0;
   localparam logic [CFG_W-1:0] OFFSET_RESET = 4'd2;
   localparam logic [CFG_W-1:0] SET_RESET    = 4'd4;
   localparam logic [CFG_W-1:0] WAY_RESET    = 4'd2;

   // Register map, one 32-bit word each.
   typedef enum logic [1:0] {
      REG_POLICY = 2'd0,
      REG_OFFSET = 2'd1,
      REG_SETS   = 2'd2,
      REG_WAYS   = 2'd3
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_PICK,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Per-line bookkeeping held in one memory word.
   typedef struct packed {
      logic             valid;
      logic             dirty;
      logic [AGE_W-1:0] age;
   } meta_type;

endpackage

// ===== rtl/core/set_assoc_cache_tag_store_core.sv =====
// Channel   Dir  Beat contents
// req_*     in   tdata: address; tuser: operation (0 read, 1 write)
// rsp_*     out  tdata: set_index, line_index, tag_value, memory_block; tuser: hit
// csr_*     in   APB registers: policy at 0x0, offset bits 0x4, set bits 0x8, way bits 0xC
//
// An access reads the ways of the set one per cycle from the tag and line-state memories,
// once to search and once more to update ages and flags.
// After reset a clearing pass writes every entry of the line-state and FIFO memories
// before the first request beat is taken. The result sits in an output register, so the
// next request is taken while a result is still stalled; a finished access waits only
// if the previous result has not been taken yet.
module set_assoc_cache_tag_store_core #(
   parameter int NUM_LINES = sactag_pkg::NUM_LINES_DEF,
   parameter int ADDR_BITS = sactag_pkg::ADDR_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [ADDR_BITS-1:0] address, zero padding above
   input  logic [((ADDR_BITS + 7) / 8) * 8-1:0] req_tdata,
   // [0] operation
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [7:0] set_index, [15:8] line_index, [29:16] tag_value, [43:30] memory_block
   output logic [47:0]                          rsp_tdata,
   // [0] hit
   output logic                                 rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [sactag_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [sactag_pkg::CSR_W-1:0]         csr_pwdata,
   output logic [sactag_pkg::CSR_W-1:0]         csr_prdata,
   output logic                                 csr_pready
);
   import sactag_pkg::*;

   localparam int IDX_W   = $clog2(NUM_LINES);
   localparam int LG      = $clog2(NUM_LINES + 1) - 1;
   localparam int EXT_W0  = (ADDR_BITS > IDX_W) ? ADDR_BITS : IDX_W;
   localparam int EXT_W   = (EXT_W0 > TAG_W) ? EXT_W0 : TAG_W;
   localparam int WIDE_W  = (IDX_W > OUT_IDX_W) ? IDX_W : OUT_IDX_W;
   localparam logic [CFG_W-1:0] LG_CFG = CFG_W'(LG);

   // Configuration registers
   logic             policy_ff;
   logic [CFG_W-1:0] offset_bits_ff, set_bits_ff, way_bits_ff;
   logic             csr_write;

   // Sequencer and datapath registers
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic             op_ff, op_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] set_ff, set_in;
   logic [IDX_W-1:0] base_ff, base_in;
   logic [IDX_W-1:0] way_mask_ff, way_mask_in;
   logic [IDX_W:0]   ways_ff, ways_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [TAG_W-1:0] block_ff, block_in;
   logic [IDX_W:0]   rw_ff, rw_in;
   logic             chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0] chk_way_ff, chk_way_in;
   logic             hit_ff, hit_in;
   logic [IDX_W-1:0] hit_way_ff, hit_way_in;
   logic             inv_ff, inv_in;
   logic [IDX_W-1:0] inv_way_ff, inv_way_in;
   logic [AGE_W-1:0] best_age_ff, best_age_in;
   logic [IDX_W-1:0] best_way_ff, best_way_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [47:0]      rsp_data_ff, rsp_data_in;

   // Memories
   meta_type         meta_mem [NUM_LINES];
   logic [TAG_W-1:0] tag_mem  [NUM_LINES];
   logic [IDX_W-1:0] fifo_mem [NUM_LINES];
   meta_type         meta_q;
   logic [TAG_W-1:0] tag_q;
   logic [IDX_W-1:0] fifo_q;

   // Sequencer outputs
   logic             issue;
   logic             meta_we, fifo_we, tag_we, rsp_load;
   logic [IDX_W-1:0] meta_waddr, fifo_waddr, rd_addr;
   meta_type         meta_wdata, meta_upd;
   logic [IDX_W-1:0] fifo_wdata;

   // Geometry of the accepted address
   logic [CFG_W-1:0] wb, sb, room;
   logic [EXT_W-1:0] addr_ext, block_ext, tag_ext;
   logic [IDX_W-1:0] set_mask;
   logic [IDX_W-1:0] line_addr;
   logic [WIDE_W-1:0] set_wide, line_wide;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_reg_type'(csr_paddr[3:2]))
         REG_POLICY: csr_prdata = CSR_W'(policy_ff);
         REG_OFFSET: csr_prdata = CSR_W'(offset_bits_ff);
         REG_SETS:   csr_prdata = CSR_W'(set_bits_ff);
         REG_WAYS:   csr_prdata = CSR_W'(way_bits_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff      <= POLICY_RESET;
         offset_bits_ff <= OFFSET_RESET;
         set_bits_ff    <= SET_RESET;
         way_bits_ff    <= WAY_RESET;
      end else if (csr_write) begin
         unique case (csr_reg_type'(csr_paddr[3:2]))
            REG_POLICY: policy_ff      <= csr_pwdata[0];
            REG_OFFSET: offset_bits_ff <= csr_pwdata[CFG_W-1:0];
            REG_SETS:   set_bits_ff    <= csr_pwdata[CFG_W-1:0];
            REG_WAYS:   way_bits_ff    <= csr_pwdata[CFG_W-1:0];
         endcase
      end
   end

   // ---------------- address split ----------------
   // Way bits are clamped to the log2 of the line count first, set bits to what is left.
   always_comb begin
      wb        = (way_bits_ff > LG_CFG) ? LG_CFG : way_bits_ff;
      room      = LG_CFG - wb;
      sb        = (set_bits_ff > room) ? room : set_bits_ff;
      addr_ext  = EXT_W'(addr_ff);
      block_ext = addr_ext >> offset_bits_ff;
      tag_ext   = block_ext >> sb;
      set_mask  = ~({IDX_W{1'b1}} << sb);
   end

   assign line_addr = IDX_W'(base_ff + chk_way_ff);
   assign rd_addr   = IDX_W'(base_ff + rw_ff[IDX_W-1:0]);

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:  if (clr_idx_ff == IDX_W'(NUM_LINES - 1)) state_in = ST_IDLE;
         ST_IDLE:   if (req_tvalid) state_in = ST_SETUP;
         ST_SETUP:  state_in = ST_SCAN;
         ST_SCAN:   if (rw_ff == ways_ff) state_in = ST_PICK;
         ST_PICK:   state_in = ST_UPDATE;
         ST_UPDATE: if (rw_ff == ways_ff) state_in = ST_DONE;
         ST_DONE:   if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:   state_in = ST_CLEAR;
      endcase
   end

   // New line state for the way checked this cycle during the update pass.
   always_comb begin
      meta_upd = meta_q;
      if (chk_way_ff == victim_ff) begin
         meta_upd.valid = 1'b1;
         meta_upd.dirty = hit_ff ? (meta_q.dirty | op_ff) : op_ff;
         if (policy_ff) begin
            meta_upd.age = '0;
         end
      end else if (policy_ff && meta_q.valid && meta_q.age != AGE_MAX) begin
         meta_upd.age = meta_q.age + AGE_W'(1);
      end
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      meta_we    = 1'b0;
      meta_waddr = line_addr;
      meta_wdata = meta_upd;
      fifo_we    = 1'b0;
      fifo_waddr = set_ff;
      fifo_wdata = IDX_W'(victim_in + IDX_W'(1)) & way_mask_ff;
      tag_we     = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            meta_we    = 1'b1;
            meta_waddr = clr_idx_ff;
            meta_wdata = '0;
            fifo_we    = 1'b1;
            fifo_waddr = clr_idx_ff;
            fifo_wdata = '0;
         end
         ST_IDLE: req_tready = 1'b1;
         ST_SETUP: ;
         ST_SCAN: issue = (rw_ff != ways_ff);
         ST_PICK: begin
            tag_we  = !hit_ff;
            fifo_we = !hit_ff && !policy_ff;
         end
         ST_UPDATE: begin
            issue   = (rw_ff != ways_ff);
            meta_we = chk_vld_ff;
         end
         ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // ---------------- datapath next values ----------------
   always_comb begin
      clr_idx_in   = clr_idx_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      set_in       = set_ff;
      base_in      = base_ff;
      way_mask_in  = way_mask_ff;
      ways_in      = ways_ff;
      tag_in       = tag_ff;
      block_in     = block_ff;
      rw_in        = issue ? rw_ff + (IDX_W + 1)'(1) : rw_ff;
      chk_vld_in   = issue;
      chk_way_in   = issue ? rw_ff[IDX_W-1:0] : chk_way_ff;
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      inv_in       = inv_ff;
      inv_way_in   = inv_way_ff;
      best_age_in  = best_age_ff;
      best_way_in  = best_way_ff;
      victim_in    = victim_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_data_in  = rsp_data_ff;
      set_wide     = WIDE_W'(set_ff);
      line_wide    = WIDE_W'(IDX_W'(base_ff + victim_ff));

      if (state_ff == ST_CLEAR) begin
         clr_idx_in = IDX_W'(clr_idx_ff + IDX_W'(1));
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         op_in   = req_tuser;
         addr_in = req_tdata[ADDR_BITS-1:0];
      end
      if (state_ff == ST_SETUP) begin
         set_in      = block_ext[IDX_W-1:0] & set_mask;
         base_in     = IDX_W'((block_ext[IDX_W-1:0] & set_mask) << wb);
         way_mask_in = ~({IDX_W{1'b1}} << wb);
         ways_in     = (IDX_W + 1)'(1) << wb;
         tag_in      = tag_ext[TAG_W-1:0];
         block_in    = block_ext[TAG_W-1:0];
         rw_in       = '0;
         hit_in      = 1'b0;
         inv_in      = 1'b0;
         best_age_in = '0;
      end
      // The lowest matching way and the lowest invalid way win; ties on age go low.
      if (state_ff == ST_SCAN && chk_vld_ff) begin
         if (meta_q.valid && tag_q == tag_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_way_in = chk_way_ff;
         end
         if (!meta_q.valid && !inv_ff) begin
            inv_in     = 1'b1;
            inv_way_in = chk_way_ff;
         end
         if (chk_way_ff == '0 || meta_q.age > best_age_ff) begin
            best_age_in = meta_q.age;
            best_way_in = chk_way_ff;
         end
      end
      if (state_ff == ST_PICK) begin
         rw_in = '0;
         if (hit_ff) begin
            victim_in = hit_way_ff;
         end else if (policy_ff) begin
            victim_in = inv_ff ? inv_way_ff : best_way_ff;
         end else begin
            victim_in = fifo_q & way_mask_ff;
         end
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_data_in  = {4'b0, block_ff, tag_ff, line_wide[OUT_IDX_W-1:0],
                         set_wide[OUT_IDX_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      set_ff      <= set_in;
      base_ff     <= base_in;
      way_mask_ff <= way_mask_in;
      ways_ff     <= ways_in;
      tag_ff      <= tag_in;
      block_ff    <= block_in;
      rw_ff       <= rw_in;
      chk_way_ff  <= chk_way_in;
      hit_ff      <= hit_in;
      hit_way_ff  <= hit_way_in;
      inv_ff      <= inv_in;
      inv_way_ff  <= inv_way_in;
      best_age_ff <= best_age_in;
      best_way_ff <= best_way_in;
      victim_ff   <= victim_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- memories ----------------
   always_ff @(posedge clock) begin
      meta_q <= meta_mem[rd_addr];
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
   end

   // The tag store is only written on a fill; a line is read as valid only after that.
   always_ff @(posedge clock) begin
      tag_q <= tag_mem[rd_addr];
      if (tag_we) begin
         tag_mem[IDX_W'(base_ff + victim_in)] <= tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      fifo_q <= fifo_mem[set_ff];
      if (fifo_we) begin
         fifo_mem[fifo_waddr] <= fifo_wdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_hit_ff;

endmodule
